### rtl/deque_rotate_pairswap_defines.svh
// Assertion macros shared by the deque RTL.
`ifndef DEQUE_ROTATE_PAIRSWAP_DEFINES_SVH
`define DEQUE_ROTATE_PAIRSWAP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, held off while reset is asserted.
`define DQRP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property, also active during reset.
`define DQRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DQRP_ASSERT(lbl, clk, rstn, prop, msg)
`define DQRP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/dqrp_pkg.sv
// Shared types and constants for the deque ring buffer.
package dqrp_pkg;

  localparam int DEPTH = 64;                // power of two
  localparam int AW    = $clog2(DEPTH);     // slot index width
  localparam int CW    = AW + 1;            // element count width

  localparam logic [2:0] KIND_APPEND  = 3'd0;
  localparam logic [2:0] KIND_PREPEND = 3'd1;
  localparam logic [2:0] KIND_REMOVE  = 3'd2;
  localparam logic [2:0] KIND_SWAP    = 3'd3;
  localparam logic [2:0] KIND_ROTATE  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_FEW  = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_ROT_WR,
    S_SW_RD,
    S_SW_WA,
    S_SW_WB,
    S_FIN_RD,
    S_FIN_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;     // capture operation
    logic ins;       // append or prepend write
    logic rem;       // drop back element
    logic rd_rot;    // read back element for rotate
    logic rot_wr;    // write it ahead of front
    logic sw_init;   // clear pair index
    logic rd_sw;     // read current pair
    logic sw_wa;     // write first slot of pair
    logic sw_wb;     // write second slot, advance pair
    logic rd_fin;    // read front and back for the result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] kind;
    logic       ok;
    logic       empty;
    logic       sw_last;
  } sts_t;

endpackage

### rtl/deque_rotate_pairswap.sv
// Top level of the deque ring buffer with rotate and pair swap.
//
//   channel | ports                  | beat taken when
//   --------+------------------------+---------------------------
//   input   | start, busy, in_data   | start high and busy low
//   result  | out_valid, out_data    | out_valid high (one cycle)
//
// Append, prepend, remove and unused kinds run from the accepting edge to
// the result beat through execute, a registered read of front and back, and
// the result state. Rotate on a non-empty list adds its write ahead of the
// front. Swap, when the list holds a pair, adds a read and two writes per
// adjacent pair, since the single write port takes one slot at a time. The
// block returns to idle after each result before the next beat is taken.
// Reset clears count and front pointer; memory contents stay unknown.
// Results cannot be stalled: each beat shows for exactly one cycle.
`include "deque_rotate_pairswap_defines.svh"

module deque_rotate_pairswap (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  dqrp_pkg::in_t  in_data,
  output logic           out_valid,
  output dqrp_pkg::out_t out_data
);

  dqrp_pkg::cmd_t cmd;
  dqrp_pkg::sts_t sts;

  logic out_empty;
  logic out_zero;
  logic out_in_range;

  dqrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  dqrp_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  assign out_empty    = (out_data.count == '0);
  assign out_zero     = (out_data.front_value == '0) && (out_data.back_value == '0);
  assign out_in_range = (out_data.count <= 7'(dqrp_pkg::DEPTH));

  // An accepted beat keeps the block busy until its result goes out.
  `DQRP_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accept did not set busy")
  // A result beat lasts exactly one cycle.
  `DQRP_ASSERT(a_strobe_one, clk, rst_n, out_valid |=> !out_valid, "result strobe held")
  // The block goes idle right after a result beat.
  `DQRP_ASSERT(a_idle_after, clk, rst_n, out_valid |=> !busy, "not idle after result")
  // Count never exceeds the store.
  `DQRP_ASSERT(a_count_max, clk, rst_n, out_valid |-> out_in_range, "count overflow")
  // An empty list reports zero values.
  `DQRP_ASSERT(a_empty_zero, clk, rst_n, (out_valid && out_empty) |-> out_zero, "empty not zero")

endmodule

### rtl/dqrp_datapath.sv
// Ring buffer storage, pointers and result registers for the deque.
module dqrp_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  dqrp_pkg::in_t  in_data,
  input  dqrp_pkg::cmd_t cmd,
  output dqrp_pkg::sts_t sts,
  output dqrp_pkg::out_t out_data
);

  localparam int AW = dqrp_pkg::AW;
  localparam int CW = dqrp_pkg::CW;

  logic [31:0]   mem [dqrp_pkg::DEPTH];

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pair_r, pair_nxt;
  logic [2:0]    kind_r;
  logic [31:0]   value_r;
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   rda_r, rdb_r;

  logic          we;
  logic [AW-1:0] waddr, ra, rb;
  logic [31:0]   wdata;
  logic          rd_en;
  logic [AW-1:0] back_slot, front_m1, pair_slot;
  logic [CW-1:0] count_m1;

  assign count_m1  = count_r - CW'(1);
  assign back_slot = front_r + count_m1[AW-1:0];
  assign front_m1  = front_r - AW'(1);
  assign pair_slot = front_r + pair_r[AW-1:0];

  // Status of the incoming operation, judged on the count before it.
  always_comb begin
    status_nxt = dqrp_pkg::ST_OK;
    case (in_data.kind)
      dqrp_pkg::KIND_APPEND, dqrp_pkg::KIND_PREPEND: begin
        if (count_r == CW'(dqrp_pkg::DEPTH)) status_nxt = dqrp_pkg::ST_FULL;
      end
      dqrp_pkg::KIND_REMOVE: begin
        if (count_r == '0) status_nxt = dqrp_pkg::ST_FEW;
      end
      dqrp_pkg::KIND_SWAP: begin
        if (count_r < CW'(2)) status_nxt = dqrp_pkg::ST_FEW;
      end
      default: status_nxt = dqrp_pkg::ST_OK;
    endcase
  end

  // Write port select.
  always_comb begin
    we    = 1'b0;
    waddr = front_m1;
    wdata = value_r;
    if (cmd.ins) begin
      we = 1'b1;
      if (kind_r == dqrp_pkg::KIND_APPEND) waddr = front_r + count_r[AW-1:0];
      else                                  waddr = front_m1;
    end else if (cmd.rot_wr) begin
      we    = 1'b1;
      wdata = rda_r;
    end else if (cmd.sw_wa) begin
      we    = 1'b1;
      waddr = pair_slot;
      wdata = rdb_r;
    end else if (cmd.sw_wb) begin
      we    = 1'b1;
      waddr = pair_slot + AW'(1);
      wdata = rda_r;
    end
  end

  // Read port select.
  always_comb begin
    rd_en = cmd.rd_rot | cmd.rd_sw | cmd.rd_fin;
    ra    = back_slot;
    rb    = back_slot;
    if (cmd.rd_sw) begin
      ra = pair_slot;
      rb = pair_slot + AW'(1);
    end else if (cmd.rd_fin) begin
      ra = front_r;
      rb = back_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rda_r <= mem[ra];
      rdb_r <= mem[rb];
    end
  end

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    pair_nxt  = pair_r;
    if (cmd.ins) begin
      count_nxt = count_r + CW'(1);
      if (kind_r == dqrp_pkg::KIND_PREPEND) front_nxt = front_m1;
    end
    if (cmd.rem)     count_nxt = count_m1;
    if (cmd.rot_wr)  front_nxt = front_m1;
    if (cmd.sw_init) pair_nxt  = '0;
    if (cmd.sw_wb)   pair_nxt  = pair_r + CW'(2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pair_r <= pair_nxt;
    if (cmd.latch) begin
      kind_r   <= in_data.kind;
      value_r  <= in_data.value;
      status_r <= status_nxt;
    end
  end

  assign sts.kind    = kind_r;
  assign sts.ok      = (status_r == dqrp_pkg::ST_OK);
  assign sts.empty   = (count_r == '0);
  assign sts.sw_last = ((pair_r + CW'(3)) >= count_r);

  assign out_data.status      = status_r;
  assign out_data.count       = 7'(count_r);
  assign out_data.front_value = (count_r == '0) ? '0 : rda_r;
  assign out_data.back_value  = (count_r == '0) ? '0 : rdb_r;

endmodule

### rtl/dqrp_ctrl.sv
// Operation sequencer for the deque.
module dqrp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  dqrp_pkg::sts_t sts,
  output dqrp_pkg::cmd_t cmd,
  output logic           busy,
  output logic           out_valid
);

  dqrp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= dqrp_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dqrp_pkg::S_IDLE: begin
        if (start) state_nxt = dqrp_pkg::S_EXEC;
      end
      dqrp_pkg::S_EXEC: begin
        state_nxt = dqrp_pkg::S_FIN_RD;
        if (sts.kind == dqrp_pkg::KIND_ROTATE && !sts.empty)
          state_nxt = dqrp_pkg::S_ROT_WR;
        else if (sts.kind == dqrp_pkg::KIND_SWAP && sts.ok)
          state_nxt = dqrp_pkg::S_SW_RD;
      end
      dqrp_pkg::S_ROT_WR:  state_nxt = dqrp_pkg::S_FIN_RD;
      dqrp_pkg::S_SW_RD:   state_nxt = dqrp_pkg::S_SW_WA;
      dqrp_pkg::S_SW_WA:   state_nxt = dqrp_pkg::S_SW_WB;
      dqrp_pkg::S_SW_WB: begin
        if (sts.sw_last) state_nxt = dqrp_pkg::S_FIN_RD;
        else             state_nxt = dqrp_pkg::S_SW_RD;
      end
      dqrp_pkg::S_FIN_RD:  state_nxt = dqrp_pkg::S_FIN_OUT;
      dqrp_pkg::S_FIN_OUT: state_nxt = dqrp_pkg::S_IDLE;
      default:             state_nxt = dqrp_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      dqrp_pkg::S_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      dqrp_pkg::S_EXEC: begin
        case (sts.kind)
          dqrp_pkg::KIND_APPEND, dqrp_pkg::KIND_PREPEND: cmd.ins = sts.ok;
          dqrp_pkg::KIND_REMOVE: cmd.rem     = sts.ok;
          dqrp_pkg::KIND_SWAP:   cmd.sw_init = sts.ok;
          dqrp_pkg::KIND_ROTATE: cmd.rd_rot  = !sts.empty;
          default:               cmd         = '0;
        endcase
      end
      dqrp_pkg::S_ROT_WR:  cmd.rot_wr = 1'b1;
      dqrp_pkg::S_SW_RD:   cmd.rd_sw  = 1'b1;
      dqrp_pkg::S_SW_WA:   cmd.sw_wa  = 1'b1;
      dqrp_pkg::S_SW_WB:   cmd.sw_wb  = 1'b1;
      dqrp_pkg::S_FIN_RD:  cmd.rd_fin = 1'b1;
      dqrp_pkg::S_FIN_OUT: out_valid  = 1'b1;
      default:             busy       = 1'b1;
    endcase
  end

endmodule

### tb/tb_deque_rotate_pairswap.sv
// Self-checking testbench for the deque ring buffer with rotate and pair swap.
module tb_deque_rotate_pairswap;

  // The slowest single op is a full-list swap: a read and two writes per pair, 32 pairs.
  // At most ~1850 ops, each with a random idle gap before it, so LIMIT_CYCLES is
  // several times over the slowest legal run.
  localparam int LIMIT_CYCLES = 600000;
  localparam int TAIL_CYCLES  = 20;     // quiet time after the last result
  localparam int RAND_OPS     = 1800;

  typedef struct {
    dqrp_pkg::in_t beat;
    int  gap;     // idle cycles before this beat is offered
    bit  drain;   // hold the beat until every result is back
  } deque_op_t;

  logic           clk   = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  dqrp_pkg::in_t  in_data = '0;
  logic           busy;
  logic           out_valid;
  dqrp_pkg::out_t out_data;

  deque_rotate_pairswap dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the deque: ring storage, head slot and element count.
  logic signed [31:0]      shadow_ring [dqrp_pkg::DEPTH];
  logic [dqrp_pkg::AW-1:0] shadow_head = '0;
  int                      shadow_count = 0;

  deque_op_t      pending_ops[$];   // beats not yet offered to the block
  dqrp_pkg::out_t expected_q[$];    // results owed by the block, oldest first
  int             error_count = 0;
  int             cycle_count = 0;

  // Apply one beat to the shadow deque and return the result it must produce.
  function automatic dqrp_pkg::out_t apply_deque_op(dqrp_pkg::in_t beat);
    dqrp_pkg::out_t          res;
    logic [dqrp_pkg::AW-1:0] a;
    logic [dqrp_pkg::AW-1:0] b;
    logic signed [31:0]      tmp;
    res = '0;
    res.status = dqrp_pkg::ST_OK;
    case (beat.kind)
      dqrp_pkg::KIND_APPEND: begin
        if (shadow_count >= dqrp_pkg::DEPTH) begin
          res.status = dqrp_pkg::ST_FULL;
        end else begin
          shadow_ring[dqrp_pkg::AW'(shadow_head + shadow_count)] = beat.value;
          shadow_count++;
        end
      end
      dqrp_pkg::KIND_PREPEND: begin
        if (shadow_count >= dqrp_pkg::DEPTH) begin
          res.status = dqrp_pkg::ST_FULL;
        end else begin
          shadow_head = shadow_head - 1'b1;   // wraps through the ring
          shadow_ring[shadow_head] = beat.value;
          shadow_count++;
        end
      end
      dqrp_pkg::KIND_REMOVE: begin
        if (shadow_count == 0) res.status = dqrp_pkg::ST_FEW;
        else shadow_count--;
      end
      dqrp_pkg::KIND_SWAP: begin
        if (shadow_count < 2) begin
          res.status = dqrp_pkg::ST_FEW;
        end else begin
          // odd tail element is left where it is
          for (int i = 0; i + 1 < shadow_count; i += 2) begin
            a = dqrp_pkg::AW'(shadow_head + i);
            b = dqrp_pkg::AW'(shadow_head + i + 1);
            tmp = shadow_ring[a];
            shadow_ring[a] = shadow_ring[b];
            shadow_ring[b] = tmp;
          end
        end
      end
      dqrp_pkg::KIND_ROTATE: begin
        // back element moves ahead of the front; no-op on an empty list
        if (shadow_count != 0) begin
          tmp = shadow_ring[dqrp_pkg::AW'(shadow_head + shadow_count - 1)];
          shadow_head = shadow_head - 1'b1;
          shadow_ring[shadow_head] = tmp;
        end
      end
      default: ;   // unused kinds change nothing
    endcase
    res.count = 7'(shadow_count);
    if (shadow_count != 0) begin
      res.front_value = shadow_ring[shadow_head];
      res.back_value  = shadow_ring[dqrp_pkg::AW'(shadow_head + shadow_count - 1)];
    end
    return res;
  endfunction

  // Driver: a beat is taken on an edge with start high and busy low. The next
  // beat, if any and its gap is used up, goes out on that same edge so that
  // back-to-back traffic keeps start high without a glitch.
  int gap_left   = 0;
  bit gap_loaded = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) expected_q.push_back(apply_deque_op(in_data));
      if (!start || !busy) begin
        if (pending_ops.size() == 0) begin
          start <= 1'b0;
        end else begin
          if (!gap_loaded) begin
            gap_left   = pending_ops[0].gap;
            gap_loaded = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
          end else if (pending_ops[0].drain && expected_q.size() != 0) begin
            start <= 1'b0;   // let the block empty out completely
          end else begin
            start      <= 1'b1;
            in_data    <= pending_ops[0].beat;
            gap_loaded  = 1'b0;
            void'(pending_ops.pop_front());
          end
        end
      end
    end
  end

  // Monitor: every result beat is compared against the oldest expectation.
  always @(posedge clk) begin
    dqrp_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data.count);
          error_count++;
        end
        if (out_data.front_value !== want.front_value) begin
          $error("front_value: expected %0d, got %0d",
                 want.front_value, out_data.front_value);
          error_count++;
        end
        if (out_data.back_value !== want.back_value) begin
          $error("back_value: expected %0d, got %0d",
                 want.back_value, out_data.back_value);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_op(logic [2:0] kind, logic [31:0] value, int gap, bit drain);
    deque_op_t op;
    op.beat.kind  = kind;
    op.beat.value = value;
    op.gap        = gap;
    op.drain      = drain;
    pending_ops.push_back(op);
  endtask

  initial begin
    int          real_ops;
    int          roll;
    int          gap;
    bit          filling;
    bit          no_idle;
    logic [2:0]  kind;
    logic [31:0] value;

    // Directed: empty-list corner cases, unused kinds, field extremes,
    // swap with one/two/odd/even counts, rotate with one and several.
    queue_op(dqrp_pkg::KIND_REMOVE,  32'h0,        0, 1'b0);   // remove when empty
    queue_op(dqrp_pkg::KIND_SWAP,    32'h0,        3, 1'b0);   // swap when empty
    queue_op(dqrp_pkg::KIND_ROTATE,  32'hFFFFFFFF, 0, 1'b0);   // rotate when empty
    queue_op(3'd5,                   32'h12345678, 1, 1'b0);
    queue_op(3'd6,                   32'hFFFFFFFF, 0, 1'b0);
    queue_op(3'd7,                   32'h0,        7, 1'b0);
    queue_op(dqrp_pkg::KIND_APPEND,  32'h7FFFFFFF, 0, 1'b0);
    queue_op(dqrp_pkg::KIND_SWAP,    32'h0,        0, 1'b0);   // too few for a pair
    queue_op(dqrp_pkg::KIND_ROTATE,  32'h0,        2, 1'b0);   // single element
    queue_op(dqrp_pkg::KIND_PREPEND, 32'h80000000, 0, 1'b0);
    queue_op(dqrp_pkg::KIND_SWAP,    32'h0,        0, 1'b0);
    queue_op(dqrp_pkg::KIND_APPEND,  32'h0,        5, 1'b0);
    queue_op(dqrp_pkg::KIND_SWAP,    32'h0,        0, 1'b0);   // odd count, tail stays
    queue_op(dqrp_pkg::KIND_APPEND,  32'hFFFFFFFF, 0, 1'b0);
    queue_op(dqrp_pkg::KIND_ROTATE,  32'h0,       19, 1'b0);
    queue_op(dqrp_pkg::KIND_SWAP,    32'h0,        0, 1'b0);
    queue_op(dqrp_pkg::KIND_REMOVE,  32'h0,        0, 1'b0);
    queue_op(dqrp_pkg::KIND_PREPEND, 32'h00000001, 1, 1'b0);
    queue_op(3'd7,                   32'h55555555, 0, 1'b0);
    for (int i = 0; i < 4; i++) queue_op(dqrp_pkg::KIND_REMOVE, 32'h0, i, 1'b0);
    queue_op(dqrp_pkg::KIND_REMOVE,  32'h0,        0, 1'b0);   // empty again

    // Random: alternate fill-biased and drain-biased stretches so the list
    // runs between empty and full; full-store inserts happen at the top.
    real_ops = 0;
    filling  = 1'b1;
    no_idle  = 1'b0;
    while (real_ops < RAND_OPS) begin
      if (real_ops % 150 == 0) filling = (real_ops / 150) % 2 == 0;
      if (real_ops % 100 == 0) no_idle = $urandom_range(0, 2) == 0;
      roll = $urandom_range(0, 99);
      if (roll < 2)               kind = 3'($urandom_range(5, 7));
      else if (roll < (filling ? 62 : 22))
        kind = $urandom_range(0, 1) ? dqrp_pkg::KIND_APPEND : dqrp_pkg::KIND_PREPEND;
      else if (roll < 72)         kind = dqrp_pkg::KIND_REMOVE;
      else if (roll < 86)         kind = dqrp_pkg::KIND_SWAP;
      else                        kind = dqrp_pkg::KIND_ROTATE;
      case ($urandom_range(0, 15))
        0:       value = 32'h7FFFFFFF;
        1:       value = 32'h80000000;
        2:       value = 32'h0;
        3:       value = 32'hFFFFFFFF;
        default: value = $urandom;
      endcase
      gap = no_idle ? 0 : $urandom_range(0, 19);
      queue_op(kind, value, gap, real_ops % 400 == 0);
      if (kind <= dqrp_pkg::KIND_ROTATE) real_ops++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || start || expected_q.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
